>>> rtl/core/integer_to_ascii_formatter_defines.svh
// Assertion macros shared by the formatter's checker.
// Depends on nothing; expects clk and arst_n in the scope of each use.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define ITA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define ITA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ita_pkg.sv
// Shared constants, state type and helpers of the integer-to-ASCII formatter.
// Depends on nothing.
package ita_pkg;

	// Widths of the conversion datapath
	localparam int unsigned MAG_W      = 64;
	localparam int unsigned BCD_DIGITS = 20;
	localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
	localparam int unsigned DAB_CNT_W  = $clog2(MAG_W + 1);
	localparam int unsigned NUM_SLOTS  = 22;
	localparam int unsigned DIG_W      = 4 * NUM_SLOTS;

	localparam int unsigned MAX_PRECISION_DEF = 40;

	// Conversion opcodes
	localparam logic [2:0] OP_CHAR   = 3'd0;
	localparam logic [2:0] OP_DEC    = 3'd1;
	localparam logic [2:0] OP_OCT    = 3'd2;
	localparam logic [2:0] OP_HEX_LO = 3'd3;
	localparam logic [2:0] OP_HEX_UP = 3'd4;

	// Characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_ONE,
		ST_SIGN,
		ST_PFX0,
		ST_PFXX,
		ST_DIGIT,
		ST_COMMA
	} ita_state_t;

	// Remainder by three of a small count: 4^k is 1 mod 3, so add the bit pairs
	function automatic logic [1:0] mod3(input logic [7:0] x);
		logic [3:0] s;
		s = 4'd0;
		for (int g = 0; g < 4; g++) begin
			s = s + 4'(x[2*g +: 2]);
		end
		if (s >= 4'd12) begin
			s = s - 4'd12;
		end
		if (s >= 4'd6) begin
			s = s - 4'd6;
		end
		if (s >= 4'd3) begin
			s = s - 4'd3;
		end
		return s[1:0];
	endfunction

endpackage

>>> rtl/core/ita_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on ita_pkg.
module ita_dabble (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ita_pkg::MAG_W-1:0]  bin,
	output logic                       busy,
	output logic [ita_pkg::BCD_W-1:0]  bcd
);
	import ita_pkg::*;

	logic [DAB_CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     adj;

	assign busy = (cnt_q != '0);
	assign bcd  = bcd_q;

	// Correct every digit of five or more before the next shift
	always_comb begin
		for (int k = 0; k < BCD_DIGITS; k++) begin
			adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
			                                          : bcd_q[4*k +: 4];
		end
	end

	// Count the remaining shifts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DAB_CNT_W'(MAG_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift the binary word into the digit register, MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy) begin
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[MAG_W-1]};
		end
	end

endmodule

>>> rtl/core/integer_to_ascii_formatter.sv
// Top level of the printf-style integer formatter: sequencer, digit shift
// register and output register. Depends on ita_pkg and ita_dabble.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | into      | in_valid/in_stall  | value opcode precision flag_plus
//          |           |                    | flag_space flag_alt flag_group
//  out     | out of    | out_valid/out_stall| char_code char_valid last bad_conversion
//
// One item at a time. Decimal: accept, conversion, normalize past leading zero digits,
// then one character per cycle while the output is not stalled; octal and hex skip the
// conversion. Single-result cases (bad opcode, empty, char) emit one beat. The
// conversion is the bit-serial BCD converter's 64 shifts and a load of its digits;
// characters leave one a cycle unless the output stalls.
// Reset returns to idle with no result pending. A stalled output holds its beat
// and freezes the emitting states; the input stalls until the item's last beat is loaded.
module integer_to_ascii_formatter #(
	parameter int unsigned MAX_PRECISION = ita_pkg::MAX_PRECISION_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [63:0] value,
	input  logic [2:0]        opcode,
	input  logic signed [6:0] precision,
	input  logic              flag_plus,
	input  logic              flag_space,
	input  logic              flag_alt,
	input  logic              flag_group,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        char_code,
	output logic              char_valid,
	output logic              last,
	output logic              bad_conversion
);
	import ita_pkg::*;

	localparam int unsigned CNT_MAX = (MAX_PRECISION > NUM_SLOTS) ? MAX_PRECISION : NUM_SLOTS;
	localparam int unsigned CW      = $clog2(CNT_MAX + 1);

	ita_state_t state_q, state_d;

	// Item registers
	logic [2:0]       op_q;
	logic             neg_q, plus_q, space_q, alt_q, group_q;
	logic [CW-1:0]    prec_q;
	logic [7:0]       one_code_q;
	logic             one_valid_q, one_bad_q;
	logic [DIG_W-1:0] dig_q;

	// Sequencer counters
	logic [CW-1:0]    nsig_q, rem_q;
	logic [1:0]       mod3_q;
	logic             pfx_q;

	// Output register
	logic             out_valid_q;
	logic [7:0]       code_q;
	logic             cvalid_q, last_q, bad_q;

	// Combinational
	logic             can_load, emit;
	logic [7:0]       o_code;
	logic             o_valid, o_last, o_bad;
	logic             bad_op, empty, single;
	logic [MAG_W-1:0] mag_c;
	logic [MAG_W+1:0] mag_ext;
	logic [DIG_W-1:0] oct_c;
	logic [6:0]       prec_sat;
	logic [CW-1:0]    prec_eff, d_c, dm1_c;
	logic             norm_done, pfx_c, has_sign, comma_c, pad_c;
	logic [3:0]       dval;
	logic [7:0]       dchar;
	logic             dab_start, dab_busy;
	logic [BCD_W-1:0] dab_bcd;

	assign can_load = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Decode the incoming item
	assign bad_op   = (opcode > OP_HEX_UP);
	assign empty    = (precision == 7'sd0) && (value == 64'sd0);
	assign single   = bad_op || empty || (opcode == OP_CHAR);
	assign mag_c    = value[63] ? 64'(~value + 64'sd1) : 64'(value);
	assign mag_ext  = {2'b00, mag_c};
	assign prec_sat = precision[6] ? 7'd1
	                : ($unsigned(precision) > 7'(MAX_PRECISION)) ? 7'(MAX_PRECISION)
	                : $unsigned(precision);
	assign prec_eff = prec_sat[CW-1:0];

	// Spread the magnitude into three-bit octal digit slots
	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			oct_c[4*k +: 4] = {1'b0, mag_ext[3*k +: 3]};
		end
	end

	assign dab_start = (state_q == ST_IDLE) && in_valid && !single && (opcode == OP_DEC);

	ita_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dab_start),
		.bin    (mag_c),
		.busy   (dab_busy),
		.bcd    (dab_bcd)
	);

	// Digit count and layout decisions
	assign norm_done = (dig_q[DIG_W-1 -: 4] != 4'd0) || (nsig_q == '0);
	assign d_c       = (nsig_q > prec_q) ? nsig_q : prec_q;
	assign dm1_c     = CW'(d_c - 1'b1);
	assign has_sign  = neg_q || plus_q || space_q;
	assign pfx_c     = alt_q && (nsig_q != '0)
	                && (((op_q == OP_OCT) && (nsig_q >= prec_q))
	                    || (op_q == OP_HEX_LO) || (op_q == OP_HEX_UP));
	assign comma_c   = (op_q == OP_DEC) && group_q && (mod3_q == 2'd0) && (rem_q != CW'(1));
	assign pad_c     = (rem_q > nsig_q);
	assign dval      = pad_c ? 4'd0 : dig_q[DIG_W-1 -: 4];
	assign dchar     = (dval < 4'd10) ? CH_ZERO + 8'(dval)
	                 : ((op_q == OP_HEX_LO) ? CH_A_LO : CH_A_UP) + 8'(dval - 4'd10);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (single) begin
						state_d = ST_ONE;
					end else if (opcode == OP_DEC) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_NORM;
					end
				end
			end
			ST_CONV: begin
				if (!dab_busy) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (norm_done) begin
					state_d = has_sign ? ST_SIGN : (pfx_c ? ST_PFX0 : ST_DIGIT);
				end
			end
			ST_ONE: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_SIGN: begin
				if (can_load) begin
					state_d = pfx_q ? ST_PFX0 : ST_DIGIT;
				end
			end
			ST_PFX0: begin
				if (can_load) begin
					state_d = (op_q == OP_OCT) ? ST_DIGIT : ST_PFXX;
				end
			end
			ST_PFXX: begin
				if (can_load) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (can_load) begin
					priority if (rem_q == CW'(1)) begin
						state_d = ST_IDLE;
					end else if (comma_c) begin
						state_d = ST_COMMA;
					end else begin
						state_d = ST_DIGIT;
					end
				end
			end
			ST_COMMA: begin
				if (can_load) begin
					state_d = ST_DIGIT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Beat to load into the output register
	always_comb begin
		emit    = 1'b0;
		o_code  = 8'd0;
		o_valid = 1'b1;
		o_last  = 1'b0;
		o_bad   = 1'b0;
		unique case (state_q)
			ST_ONE: begin
				emit    = can_load;
				o_code  = one_code_q;
				o_valid = one_valid_q;
				o_last  = 1'b1;
				o_bad   = one_bad_q;
			end
			ST_SIGN: begin
				emit   = can_load;
				o_code = neg_q ? CH_MINUS : (plus_q ? CH_PLUS : CH_SPACE);
			end
			ST_PFX0: begin
				emit   = can_load;
				o_code = CH_ZERO;
			end
			ST_PFXX: begin
				emit   = can_load;
				o_code = (op_q == OP_HEX_LO) ? CH_X_LO : CH_X_UP;
			end
			ST_DIGIT: begin
				emit   = can_load;
				o_code = dchar;
				o_last = (rem_q == CW'(1));
			end
			ST_COMMA: begin
				emit   = can_load;
				o_code = CH_COMMA;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nsig_q      <= '0;
			rem_q       <= '0;
			mod3_q      <= 2'd0;
			pfx_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold the beat while stalled, drop it once taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					nsig_q <= CW'(NUM_SLOTS);
				end
				ST_NORM: begin
					if (norm_done) begin
						rem_q  <= d_c;
						mod3_q <= mod3(8'(dm1_c));
						pfx_q  <= pfx_c;
					end else begin
						nsig_q <= CW'(nsig_q - 1'b1);
					end
				end
				ST_DIGIT: begin
					if (can_load) begin
						rem_q  <= CW'(rem_q - 1'b1);
						mod3_q <= (mod3_q == 2'd0) ? 2'd2 : mod3_q - 2'd1;
						if (!pad_c) begin
							nsig_q <= CW'(nsig_q - 1'b1);
						end
					end
				end
				default: begin
					rem_q <= rem_q;
				end
			endcase
		end
	end

	// Item and digit registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q        <= opcode;
					neg_q       <= value[63];
					plus_q      <= flag_plus;
					space_q     <= flag_space;
					alt_q       <= flag_alt;
					group_q     <= flag_group;
					prec_q      <= prec_eff;
					one_code_q  <= (bad_op || empty) ? 8'd0 : value[7:0];
					one_valid_q <= !(bad_op || empty);
					one_bad_q   <= bad_op;
					dig_q       <= (opcode == OP_OCT) ? oct_c : DIG_W'(mag_c);
				end
			end
			ST_CONV: begin
				if (!dab_busy) begin
					dig_q <= DIG_W'(dab_bcd);
				end
			end
			ST_NORM: begin
				// advance past leading zero digits
				if (!norm_done) begin
					dig_q <= {dig_q[DIG_W-5:0], 4'd0};
				end
			end
			ST_DIGIT: begin
				if (can_load && !pad_c) begin
					dig_q <= {dig_q[DIG_W-5:0], 4'd0};
				end
			end
			default: begin
				dig_q <= dig_q;
			end
		endcase
		if (emit) begin
			code_q   <= o_code;
			cvalid_q <= o_valid;
			last_q   <= o_last;
			bad_q    <= o_bad;
		end
	end

	assign out_valid      = out_valid_q;
	assign char_code      = code_q;
	assign char_valid     = cvalid_q;
	assign last           = last_q;
	assign bad_conversion = bad_q;

endmodule

>>> rtl/core/ita_checker.sv
// Port-level checks of the integer-to-ASCII formatter, bound to the top level.
// Depends on integer_to_ascii_formatter_defines.svh.
`include "integer_to_ascii_formatter_defines.svh"

module ita_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  char_code,
	input logic        char_valid,
	input logic        last,
	input logic        bad_conversion
);

	// A stalled beat holds its payload
	`ITA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_code) && $stable(last), "stalled output beat changed")

	// A bad opcode gives one empty, final beat
	`ITA_ASSERT_NOW(a_bad_final, out_valid && bad_conversion, last && !char_valid, "bad conversion beat not final or carries a character")

	// An empty beat always closes its item
	`ITA_ASSERT_NOW(a_empty_final, out_valid && !char_valid, last, "empty beat not marked last")

	// One item at a time: input stalls right after an accept
	`ITA_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "input not stalled after accept")

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for integer_to_ascii_formatter: directed and random
// format requests, a text predictor, and a character-by-character checker.
// Depends on ita_pkg and the formatter RTL.
`timescale 1ns / 100ps

module testbench;
	import ita_pkg::*;

	// Opcodes that the block must reject
	localparam logic [2:0] OP_RSVD_A = 3'd5;
	localparam logic [2:0] OP_RSVD_B = 3'd6;
	localparam logic [2:0] OP_RSVD_C = 3'd7;

	localparam int PREC_CAP    = MAX_PRECISION_DEF;
	localparam int RANDOM_REQS = 175;
	localparam int IDLE_PCT    = 9;
	localparam int QUIET_FROM  = 2000;
	localparam int QUIET_TO    = 5000;
	localparam int HOLD_AT     = 1200;
	localparam int HOLD_LEN    = 400;
	localparam int DRAIN_CYC   = 200;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic signed [63:0] value;
		logic [2:0]         opcode;
		logic signed [6:0]  precision;
		logic               flag_plus;
		logic               flag_space;
		logic               flag_alt;
		logic               flag_group;
	} fmt_req_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       char_valid;
		logic       last;
		logic       bad_conversion;
	} fmt_char_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic signed [63:0] value = '0;
	logic [2:0]        opcode = OP_CHAR;
	logic signed [6:0] precision = '0;
	logic              flag_plus = 1'b0;
	logic              flag_space = 1'b0;
	logic              flag_alt = 1'b0;
	logic              flag_group = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        char_code;
	logic              char_valid;
	logic              last;
	logic              bad_conversion;

	fmt_req_t  reqs_q[$];
	fmt_char_t chars_due[$];
	logic      in_beat_taken = 1'b0;
	int        cyc = 0;
	int        hold_left = 0;
	int        mismatches = 0;
	logic      quiet;

	integer_to_ascii_formatter u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value          (value),
		.opcode         (opcode),
		.precision      (precision),
		.flag_plus      (flag_plus),
		.flag_space     (flag_space),
		.flag_alt       (flag_alt),
		.flag_group     (flag_group),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.char_code      (char_code),
		.char_valid     (char_valid),
		.last           (last),
		.bad_conversion (bad_conversion)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Stretch with no idling on either side
	assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

	// Build the expected text of one request, one character per beat
	function automatic void format_chars(input fmt_req_t req);
		logic [63:0] mag;
		logic [63:0] rest;
		logic [63:0] radix;
		logic [7:0]  txt[$];
		logic [3:0]  digit[64];
		int          prec;
		int          ndig;
		int          width;
		int          i;
		if (req.opcode > OP_HEX_UP) begin
			chars_due.push_back({8'h00, 1'b0, 1'b1, 1'b1});
			return;
		end
		prec = $signed(req.precision);
		if (prec == 0 && req.value == 64'sd0) begin
			chars_due.push_back({8'h00, 1'b0, 1'b1, 1'b0});
			return;
		end
		if (prec < 0) begin
			prec = 1;
		end
		if (prec > PREC_CAP) begin
			prec = PREC_CAP;
		end
		if (req.opcode == OP_CHAR) begin
			chars_due.push_back({req.value[7:0], 1'b1, 1'b1, 1'b0});
			return;
		end

		// Digits come from the magnitude, least significant first
		mag = req.value[63] ? (~req.value + 64'd1) : req.value;
		radix = (req.opcode == OP_DEC) ? 64'd10 : (req.opcode == OP_OCT) ? 64'd8 : 64'd16;
		ndig = 0;
		rest = mag;
		while (rest != 64'd0) begin
			digit[ndig] = 4'(rest % radix);
			rest = rest / radix;
			ndig++;
		end
		width = (ndig < prec) ? prec : ndig;
		for (i = ndig; i < width; i++) begin
			digit[i] = 4'd0;
		end

		if (req.value[63]) begin
			txt.push_back(CH_MINUS);
		end else if (req.flag_plus) begin
			txt.push_back(CH_PLUS);
		end else if (req.flag_space) begin
			txt.push_back(CH_SPACE);
		end

		// Octal prefix only when no padding zero leads already
		if (req.flag_alt && mag != 64'd0) begin
			if (req.opcode == OP_OCT) begin
				if (width == ndig) begin
					txt.push_back(CH_ZERO);
				end
			end else if (req.opcode == OP_HEX_LO || req.opcode == OP_HEX_UP) begin
				txt.push_back(CH_ZERO);
				txt.push_back((req.opcode == OP_HEX_LO) ? CH_X_LO : CH_X_UP);
			end
		end

		for (i = width - 1; i >= 0; i--) begin
			if (digit[i] < 4'd10) begin
				txt.push_back(CH_ZERO + 8'(digit[i]));
			end else if (req.opcode == OP_HEX_LO) begin
				txt.push_back(CH_A_LO + 8'(digit[i]) - 8'd10);
			end else begin
				txt.push_back(CH_A_UP + 8'(digit[i]) - 8'd10);
			end
			if (req.opcode == OP_DEC && req.flag_group && i > 0 && (i % 3) == 0) begin
				txt.push_back(CH_COMMA);
			end
		end

		foreach (txt[k]) begin
			chars_due.push_back({txt[k], 1'b1, k == txt.size() - 1, 1'b0});
		end
	endfunction

	task automatic queue_req(input logic signed [63:0] v, input logic [2:0] op, input int prec,
			input bit fp, input bit fs, input bit fa, input bit fg);
		reqs_q.push_back({v, op, 7'(prec), fp, fs, fa, fg});
	endtask

	task automatic note_mismatch(input fmt_char_t want, input fmt_char_t seen, input bit stray);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			if (stray) begin
				$display("unexpected beat: char %h valid %b last %b bad %b", seen.char_code,
					seen.char_valid, seen.last, seen.bad_conversion);
			end else begin
				$display("mismatch: expected char %h valid %b last %b bad %b, got %h %b %b %b",
					want.char_code, want.char_valid, want.last, want.bad_conversion,
					seen.char_code, seen.char_valid, seen.last, seen.bad_conversion);
			end
		end
	endtask

	// Driver: hold an unaccepted beat, otherwise offer the next request or idle
	always @(negedge clk) begin : driver
		fmt_req_t next_req;
		if (arst_n && !(in_valid && !in_beat_taken)) begin
			if (reqs_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				next_req = reqs_q.pop_front();
				value <= next_req.value;
				opcode <= next_req.opcode;
				precision <= next_req.precision;
				flag_plus <= next_req.flag_plus;
				flag_space <= next_req.flag_space;
				flag_alt <= next_req.flag_alt;
				flag_group <= next_req.flag_group;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off so the block backs up into its input
	always @(negedge clk) begin
		if (cyc == HOLD_AT) begin
			hold_left <= HOLD_LEN;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		out_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < IDLE_PCT);
	end

	// Monitor: predict on each input beat, check each output beat
	always @(posedge clk) begin : monitor
		fmt_char_t seen;
		fmt_char_t want;
		in_beat_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			format_chars({value, opcode, precision, flag_plus, flag_space, flag_alt,
				flag_group});
		end
		if (arst_n && out_valid && !out_stall) begin
			seen = {char_code, char_valid, last, bad_conversion};
			if (chars_due.size() == 0) begin
				note_mismatch(seen, seen, 1'b1);
			end else begin
				want = chars_due.pop_front();
				if (seen !== want) begin
					note_mismatch(want, seen, 1'b0);
				end
			end
		end
	end

	initial begin : stimulus
		logic signed [63:0] v;
		logic [2:0]         op;
		int                 prec;

		// Empty text, zero padding, extremes, prefixes, grouping, bad opcodes
		queue_req(64'sd0, OP_DEC, -1, 0, 0, 0, 0);
		queue_req(64'sd0, OP_DEC, 0, 1, 1, 1, 1);
		queue_req(64'sd0, OP_HEX_UP, 0, 0, 0, 1, 0);
		queue_req(64'sd0, OP_CHAR, 0, 0, 0, 0, 0);
		queue_req(64'sd0, OP_CHAR, -1, 1, 1, 1, 1);
		queue_req(64'sh41, OP_CHAR, 63, 1, 0, 1, 1);
		queue_req(-64'sd1, OP_CHAR, 5, 0, 0, 0, 0);
		queue_req(64'sh7FFFFFFFFFFFFFFF, OP_DEC, -1, 1, 0, 0, 1);
		queue_req(64'sh8000000000000000, OP_DEC, 40, 0, 0, 0, 1);
		queue_req(64'sh8000000000000000, OP_OCT, -1, 1, 1, 1, 0);
		queue_req(-64'sd1, OP_HEX_LO, -1, 1, 0, 1, 0);
		queue_req(64'sh7FFFFFFFFFFFFFFF, OP_HEX_UP, 1, 0, 1, 1, 0);
		queue_req(64'sd8, OP_OCT, 5, 0, 0, 1, 0);
		queue_req(64'sd8, OP_OCT, 1, 0, 1, 1, 0);
		queue_req(64'sd0, OP_OCT, -1, 0, 0, 1, 0);
		queue_req(64'sd0, OP_HEX_LO, 3, 1, 0, 1, 0);
		queue_req(64'sd0, OP_DEC, 40, 0, 1, 0, 1);
		queue_req(64'sd1234567, OP_DEC, -1, 0, 1, 0, 1);
		queue_req(-64'sd42, OP_DEC, -64, 1, 1, 0, 1);
		queue_req(64'shABC, OP_HEX_LO, 63, 0, 0, 1, 0);
		queue_req(64'shABC, OP_HEX_UP, 4, 0, 0, 0, 1);
		queue_req(64'sd999, OP_OCT, 40, 1, 0, 0, 1);
		queue_req(64'sd0, OP_RSVD_A, 0, 0, 0, 0, 0);
		queue_req(-64'sd5, OP_RSVD_B, 3, 1, 0, 1, 0);
		queue_req(64'sd99, OP_RSVD_C, -1, 1, 1, 1, 1);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			case ($urandom_range(7))
			0, 1: v = {$urandom, $urandom};
			2: v = 64'($urandom_range(1000));
			3: v = -64'($urandom_range(100000, 1));
			4: v = 64'd1 << $urandom_range(63);
			5: v = {$urandom, $urandom} >> $urandom_range(63);
			6: v = $urandom_range(1) ? 64'sh7FFFFFFFFFFFFFFF : 64'sh8000000000000000;
			default: v = $urandom_range(1) ? 64'sd0 : -64'sd1;
			endcase
			if ($urandom_range(15) == 0) begin
				op = 3'($urandom_range(OP_RSVD_C, OP_RSVD_A));
			end else begin
				op = 3'($urandom_range(OP_HEX_UP, OP_CHAR));
			end
			case ($urandom_range(7))
			0: prec = -1;
			1: prec = 0;
			2, 3, 4: prec = int'($urandom_range(12, 1));
			5: prec = int'($urandom_range(PREC_CAP, 13));
			6: prec = int'($urandom_range(127)) - 64;
			default: prec = 1;
			endcase
			queue_req(v, op, prec, 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every character to come out
		while (reqs_q.size() != 0 || in_valid || chars_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
